### hdl/tppse_pkg.sv
// shared types and constants of the three-phase pattern section extractor
// item and result structs, command codes, phase and sequencer enums
// no dependencies
package tppse_pkg;

    localparam int WINDOW_BYTES_DEF = 64;
    localparam int LINE_BYTES_DEF   = 64;

    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_LEN     = 2'd2;

    localparam logic [1:0] CMD_SCAN    = 2'd0;
    localparam logic [1:0] CMD_LOAD    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic [1:0] SEL_TRIGGER = 2'd0;
    localparam logic [1:0] SEL_MATCH   = 2'd1;
    localparam logic [1:0] SEL_END     = 2'd2;

    localparam int NUM_PATTERNS = 3;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    localparam logic STOP_END      = 1'b0;
    localparam logic STOP_OVERFLOW = 1'b1;

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] pattern_select;
        logic [5:0] pattern_position;
        logic [7:0] value;
        logic       chunk_end;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_status;
        logic       stop_cause;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [CFG_W-1:0] trigger_length;
        logic [CFG_W-1:0] match_length;
        logic [CFG_W-1:0] end_length;
    } t_cfg;

    typedef enum logic [1:0] {
        OP_SCAN,
        OP_LOAD,
        OP_RESTART
    } t_op_kind;

    typedef struct packed {
        t_op_kind   kind;
        logic [1:0] sel;
        logic [5:0] pos;
        logic [7:0] value;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_op_if;

    typedef enum logic [1:0] {
        PH_TRIGGER,
        PH_MATCH,
        PH_TEXT,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_CMP,
        BS_EMIT_MATCH,
        BS_EMIT_LINE
    } t_bstate;

endpackage

### hdl/tppse_front.sv
// front end: accepts input items, classifies them into operations
// and holds them in a two-entry operation queue; uses tppse_pkg
module tppse_front
    import tppse_pkg::*;
#(
    parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   push,
    output logic   full,
    input  t_item  i_item,
    output t_op_if o_op_if,
    input  logic   i_op_pop
);

    t_op        r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    logic w_keep;
    t_op  w_op;
    logic w_wr;
    logic w_rd;

    always_comb begin
        w_op.kind  = OP_SCAN;
        w_op.sel   = i_item.pattern_select;
        w_op.pos   = i_item.pattern_position;
        w_op.value = i_item.value;
        w_keep     = 1'b0;
        case (i_item.cmd)
            CMD_SCAN: begin
                w_op.kind = OP_SCAN;
                w_keep    = 1'b1;
            end
            CMD_LOAD: begin
                w_op.kind = OP_LOAD;
                w_keep    = (i_item.pattern_select <= SEL_END) &&
                            ({1'b0, i_item.pattern_position} < 7'(WINDOW_BYTES));
            end
            CMD_RESTART: begin
                w_op.kind = OP_RESTART;
                w_keep    = 1'b1;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign full    = (r_cnt == 2'd2);
    assign w_wr    = push && !full && w_keep;
    assign w_rd    = i_op_pop && (r_cnt != 2'd0);

    assign o_op_if.valid = (r_cnt != 2'd0);
    assign o_op_if.op    = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= w_op;
        end
    end

endmodule

### hdl/tppse_back.sv
// back end: sequencer that shifts the match window, compares it with the
// pattern store, buffers text lines and emits results; uses tppse_pkg
module tppse_back
    import tppse_pkg::*;
#(
    parameter int WINDOW_BYTES = WINDOW_BYTES_DEF,
    parameter int LINE_BYTES   = LINE_BYTES_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_op_if  i_op_if,
    output logic    o_op_pop,
    input  logic    i_res_full,
    output logic    o_res_push,
    output t_result o_res
);

    localparam int WIN_AW = $clog2(WINDOW_BYTES);
    localparam int LEN_W  = $clog2(WINDOW_BYTES + 1);
    localparam int LB_AW  = $clog2(LINE_BYTES);
    localparam int FILL_W = $clog2(LINE_BYTES + 1);

    t_bstate r_state;
    t_bstate n_state;
    t_phase  r_phase;
    t_phase  n_phase;

    logic [7:0]                    r_win [WINDOW_BYTES];
    logic [7:0]                    n_win [WINDOW_BYTES];
    logic [7:0]                    w_shift [WINDOW_BYTES];
    logic [WINDOW_BYTES-1:0][7:0]  r_pat_mem [NUM_PATTERNS];
    logic [WINDOW_BYTES-1:0][7:0]  r_row;
    logic [WINDOW_BYTES-1:0]       w_eq;
    logic                          w_match;

    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  n_len;
    logic [LEN_W-1:0]  r_cnt;
    logic [LEN_W-1:0]  n_cnt;
    logic [LEN_W-1:0]  w_len;
    logic [CFG_W-1:0]  w_raw_len;
    logic [7:0]        r_byte;
    logic [7:0]        n_byte;

    logic [7:0]        r_line_mem [LINE_BYTES];
    logic [7:0]        r_line_q;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [FILL_W-1:0] r_idx;
    logic [FILL_W-1:0] n_idx;

    logic       w_pat_we;
    logic       w_row_ld;
    logic       w_row_shift;
    logic       w_line_we;
    logic [1:0] w_rd_sel;

    // length of the pattern that belongs to the current phase
    always_comb begin
        case (r_phase)
            PH_TRIGGER: w_raw_len = i_cfg.trigger_length;
            PH_MATCH:   w_raw_len = i_cfg.match_length;
            default:    w_raw_len = i_cfg.end_length;
        endcase
        if (w_raw_len == '0) begin
            w_len = LEN_W'(1);
        end else if (w_raw_len > CFG_W'(WINDOW_BYTES)) begin
            w_len = LEN_W'(WINDOW_BYTES);
        end else begin
            w_len = LEN_W'(w_raw_len);
        end
        case (r_phase)
            PH_TRIGGER: w_rd_sel = SEL_TRIGGER;
            PH_MATCH:   w_rd_sel = SEL_MATCH;
            default:    w_rd_sel = SEL_END;
        endcase
    end

    for (genvar g = 0; g < WINDOW_BYTES; g++) begin : g_win
        if (g < WINDOW_BYTES - 1) begin : g_mid
            assign w_shift[g] = (LEN_W'(g + 1) < w_len)  ? r_win[g + 1] :
                                (LEN_W'(g + 1) == w_len) ? i_op_if.op.value : r_win[g];
        end else begin : g_top
            assign w_shift[g] = (LEN_W'(g + 1) == w_len) ? i_op_if.op.value : r_win[g];
        end
        assign w_eq[g] = (r_win[g] == r_row[g]) || (LEN_W'(g) >= r_len);
    end

    assign w_match = &w_eq;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: begin
                if (i_op_if.valid && (i_op_if.op.kind == OP_SCAN) && (r_phase != PH_DONE)) begin
                    n_state = BS_CMP;
                end
            end
            BS_CMP: begin
                case (r_phase)
                    PH_MATCH: begin
                        if (w_match && (r_len != LEN_W'(1))) begin
                            n_state = BS_EMIT_MATCH;
                        end else begin
                            n_state = BS_IDLE;
                        end
                    end
                    PH_TEXT: begin
                        if (w_match || (r_fill == FILL_W'(LINE_BYTES))) begin
                            if (!i_res_full) begin
                                n_state = BS_IDLE;
                            end
                        end else if (r_byte == NEWLINE_BYTE) begin
                            n_state = BS_EMIT_LINE;
                        end else begin
                            n_state = BS_IDLE;
                        end
                    end
                    default: begin
                        n_state = BS_IDLE;
                    end
                endcase
            end
            BS_EMIT_MATCH: begin
                if (!i_res_full && (r_cnt == LEN_W'(1))) begin
                    n_state = BS_IDLE;
                end
            end
            BS_EMIT_LINE: begin
                if (!i_res_full && (r_idx == r_fill)) begin
                    n_state = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_op_pop         = 1'b0;
        o_res_push       = 1'b0;
        o_res.out_byte   = '0;
        o_res.is_status  = 1'b0;
        o_res.stop_cause = STOP_END;
        o_res.last       = 1'b0;
        w_pat_we         = 1'b0;
        w_row_ld         = 1'b0;
        w_row_shift      = 1'b0;
        w_line_we        = 1'b0;
        n_phase          = r_phase;
        n_win            = r_win;
        n_len            = r_len;
        n_byte           = r_byte;
        n_cnt            = r_cnt;
        n_fill           = r_fill;
        n_idx            = r_idx;
        case (r_state)
            BS_IDLE: begin
                if (i_op_if.valid) begin
                    o_op_pop = 1'b1;
                    case (i_op_if.op.kind)
                        OP_LOAD: begin
                            w_pat_we = 1'b1;
                        end
                        OP_RESTART: begin
                            for (int i = 0; i < WINDOW_BYTES; i++) begin
                                n_win[i] = '0;
                            end
                            n_phase = PH_TRIGGER;
                            n_fill  = '0;
                        end
                        OP_SCAN: begin
                            if (r_phase != PH_DONE) begin
                                n_win    = w_shift;
                                w_row_ld = 1'b1;
                                n_len    = w_len;
                                n_byte   = i_op_if.op.value;
                            end
                        end
                        default: begin
                            o_op_pop = 1'b1;
                        end
                    endcase
                end
            end
            BS_CMP: begin
                case (r_phase)
                    PH_TRIGGER: begin
                        if (w_match) begin
                            n_phase = PH_MATCH;
                        end
                    end
                    PH_MATCH: begin
                        if (w_match) begin
                            n_phase     = PH_TEXT;
                            n_cnt       = r_len - LEN_W'(1);
                            w_row_shift = 1'b1;
                        end
                    end
                    PH_TEXT: begin
                        if (w_match || (r_fill == FILL_W'(LINE_BYTES))) begin
                            if (!i_res_full) begin
                                o_res_push       = 1'b1;
                                o_res.is_status  = 1'b1;
                                o_res.stop_cause = w_match ? STOP_END : STOP_OVERFLOW;
                                o_res.last       = 1'b1;
                                n_phase          = PH_DONE;
                            end
                        end else if (r_byte == NEWLINE_BYTE) begin
                            n_idx = '0;
                        end else begin
                            w_line_we = 1'b1;
                            n_fill    = r_fill + FILL_W'(1);
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
            BS_EMIT_MATCH: begin
                if (!i_res_full) begin
                    o_res_push     = 1'b1;
                    o_res.out_byte = r_row[0];
                    o_res.last     = (r_cnt == LEN_W'(1));
                    w_row_shift    = 1'b1;
                    n_cnt          = r_cnt - LEN_W'(1);
                end
            end
            BS_EMIT_LINE: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    if (r_idx == r_fill) begin
                        o_res.out_byte = NEWLINE_BYTE;
                        o_res.last     = 1'b1;
                        n_fill         = '0;
                    end else begin
                        o_res.out_byte = r_line_q;
                        n_idx          = r_idx + FILL_W'(1);
                    end
                end
            end
            default: begin
                o_res_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_phase <= PH_TRIGGER;
            r_fill  <= '0;
            r_idx   <= '0;
            r_cnt   <= '0;
            for (int i = 0; i < WINDOW_BYTES; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_fill  <= n_fill;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            r_win   <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len  <= n_len;
        r_byte <= n_byte;
    end

    // pattern store, one row per pattern with byte writes
    always_ff @(posedge i_clk) begin
        if (w_pat_we) begin
            r_pat_mem[i_op_if.op.sel][i_op_if.op.pos[WIN_AW-1:0]] <= i_op_if.op.value;
        end
        if (w_row_ld) begin
            r_row <= r_pat_mem[w_rd_sel];
        end else if (w_row_shift) begin
            r_row <= {8'h00, r_row[WINDOW_BYTES-1:1]};
        end
    end

    // line buffer
    always_ff @(posedge i_clk) begin
        if (w_line_we) begin
            r_line_mem[r_fill[LB_AW-1:0]] <= r_byte;
        end
        r_line_q <= r_line_mem[n_idx[LB_AW-1:0]];
    end

`ifndef SYNTHESIS
    a_push_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into full queue");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(LINE_BYTES))
        else $error("line fill beyond buffer");

    a_status_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && o_res.is_status) |=> (r_phase == PH_DONE) && (r_state == BS_IDLE))
        else $error("stop status did not finish scan");

    a_emit_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_EMIT_MATCH) |-> (r_cnt != '0) && (r_phase == PH_TEXT))
        else $error("match emission count lost");

    a_line_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_EMIT_LINE) |-> (r_idx <= r_fill))
        else $error("line read index past fill");
`endif

endmodule

### hdl/tppse_out_q.sv
// two-entry result queue between the sequencer and the result ports
// uses tppse_pkg
module tppse_out_q
    import tppse_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_full,
    output logic    empty,
    input  logic    pop,
    output t_result o_result
);

    t_result    r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    logic w_wr;
    logic w_rd;

    assign o_full   = (r_cnt == 2'd2);
    assign empty    = (r_cnt == 2'd0);
    assign w_wr     = i_push && !o_full;
    assign w_rd     = pop && !empty;
    assign o_result = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= i_res;
        end
    end

endmodule

### hdl/three_phase_pattern_section_extractor.sv
// a stop status goes from the operation queue through the sequencer's compare state
// and the result queue to the result ports; emitted text and match bytes also pass an emit state
// scan items use the idle and compare states (only idle after finish), loads and restarts idle;
// emitted text and match bytes leave at one per cycle while the result queue is not full
// reset: synchronous active low, clears queues, phase, line fill and window
// pattern store and line buffer are not cleared and need no clearing pass
module three_phase_pattern_section_extractor
    import tppse_pkg::*;
#(
    parameter int WINDOW_BYTES = WINDOW_BYTES_DEF,
    parameter int LINE_BYTES   = LINE_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  t_item                i_item,
    output logic                 empty,
    input  logic                 pop,
    output t_result              o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg    r_cfg;
    t_op_if  w_op_if;
    logic    w_op_pop;
    logic    w_res_full;
    logic    w_res_push;
    t_result w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_length <= CFG_W'(1);
            r_cfg.match_length   <= CFG_W'(1);
            r_cfg.end_length     <= CFG_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TRIGGER_LEN: r_cfg.trigger_length <= i_cfg_data;
                CFG_MATCH_LEN:   r_cfg.match_length   <= i_cfg_data;
                CFG_END_LEN:     r_cfg.end_length     <= i_cfg_data;
                default:         r_cfg                <= r_cfg;
            endcase
        end
    end

    tppse_front #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .o_op_if  (w_op_if),
        .i_op_pop (w_op_pop)
    );

    tppse_back #(
        .WINDOW_BYTES (WINDOW_BYTES),
        .LINE_BYTES   (LINE_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_op_if    (w_op_if),
        .o_op_pop   (w_op_pop),
        .i_res_full (w_res_full),
        .o_res_push (w_res_push),
        .o_res      (w_res)
    );

    tppse_out_q u_out_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_res_push),
        .i_res    (w_res),
        .o_full   (w_res_full),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

endmodule

### sim/tppse_sb_pkg.sv
// scoreboard class for the three-phase pattern section extractor testbench
// predicts result transfers from accepted items and checks them in order
// depends on tppse_pkg
package tppse_sb_pkg;
    import tppse_pkg::*;

    class section_scoreboard;
        logic [7:0]       window [WINDOW_BYTES_DEF];
        logic [7:0]       patterns [NUM_PATTERNS][WINDOW_BYTES_DEF];
        logic [7:0]       line_buf [LINE_BYTES_DEF];
        int               line_fill;
        t_phase           phase;
        logic [CFG_W-1:0] lengths [NUM_PATTERNS];
        t_result          expected_q [$];
        int               mismatches;
        int               checked;

        function new();
            foreach (window[i]) window[i] = 8'h00;
            foreach (patterns[p, i]) patterns[p][i] = 8'h00;
            foreach (line_buf[i]) line_buf[i] = 8'h00;
            foreach (lengths[p]) lengths[p] = 1;
            line_fill = 0;
            phase = PH_TRIGGER;
            mismatches = 0;
            checked = 0;
        endfunction

        function int span(logic [CFG_W-1:0] v);
            if (v == 0) return 1;
            if (v > WINDOW_BYTES_DEF) return WINDOW_BYTES_DEF;
            return int'(v);
        endfunction

        function void set_length(int idx, logic [CFG_W-1:0] v);
            lengths[idx] = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit shift_match(int n, logic [7:0] b, int sel);
            for (int i = 0; i + 1 < n; i++) window[i] = window[i+1];
            window[n-1] = b;
            for (int i = 0; i < n; i++) begin
                if (window[i] != patterns[sel][i]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void emit(logic [7:0] b, logic status, logic cause);
            t_result r;
            r.out_byte = b;
            r.is_status = status;
            r.stop_cause = cause;
            r.last = 1'b0;
            expected_q.push_back(r);
        endfunction

        function void scan(logic [7:0] b);
            int      base;
            int      n;
            t_result tail;
            base = expected_q.size();
            case (phase)
                PH_TRIGGER: begin
                    if (shift_match(span(lengths[CFG_TRIGGER_LEN]), b, SEL_TRIGGER))
                        phase = PH_MATCH;
                end
                PH_MATCH: begin
                    n = span(lengths[CFG_MATCH_LEN]);
                    if (shift_match(n, b, SEL_MATCH)) begin
                        for (int i = 1; i < n; i++) emit(patterns[SEL_MATCH][i], 1'b0, STOP_END);
                        phase = PH_TEXT;
                    end
                end
                PH_TEXT: begin
                    if (shift_match(span(lengths[CFG_END_LEN]), b, SEL_END)) begin
                        emit(8'h00, 1'b1, STOP_END);
                        phase = PH_DONE;
                    end else if (line_fill >= LINE_BYTES_DEF) begin
                        emit(8'h00, 1'b1, STOP_OVERFLOW);
                        phase = PH_DONE;
                    end else if (b == NEWLINE_BYTE) begin
                        for (int i = 0; i < line_fill; i++) emit(line_buf[i], 1'b0, STOP_END);
                        emit(NEWLINE_BYTE, 1'b0, STOP_END);
                        line_fill = 0;
                    end else begin
                        line_buf[line_fill] = b;
                        line_fill++;
                    end
                end
                default: begin
                end
            endcase
            if (expected_q.size() > base) begin
                tail = expected_q.pop_back();
                tail.last = 1'b1;
                expected_q.push_back(tail);
            end
        endfunction

        // returns 1 when the block acts on the item
        function bit note_item(t_item it);
            case (it.cmd)
                CMD_LOAD: begin
                    if (it.pattern_select >= NUM_PATTERNS) return 1'b0;
                    patterns[it.pattern_select][it.pattern_position] = it.value;
                    return 1'b1;
                end
                CMD_RESTART: begin
                    foreach (window[i]) window[i] = 8'h00;
                    phase = PH_TRIGGER;
                    line_fill = 0;
                    return 1'b1;
                end
                CMD_SCAN: begin
                    if (phase == PH_DONE) return 1'b0;
                    scan(it.value);
                    return 1'b1;
                end
                default: return 1'b0;
            endcase
        endfunction

        function void complain(string msg);
            mismatches++;
            if (mismatches <= 10) $display("%s", msg);
        endfunction

        function void check_result(t_result got);
            t_result want;
            checked++;
            if (expected_q.size() == 0) begin
                complain($sformatf("result %0d: none expected, got byte %02h status %b cause %b last %b",
                    checked, got.out_byte, got.is_status, got.stop_cause, got.last));
                return;
            end
            want = expected_q.pop_front();
            if (got.out_byte !== want.out_byte || got.is_status !== want.is_status ||
                got.stop_cause !== want.stop_cause || got.last !== want.last) begin
                complain($sformatf({"result %0d: expected byte %02h status %b cause %b last %b,",
                    " got byte %02h status %b cause %b last %b"}, checked,
                    want.out_byte, want.is_status, want.stop_cause, want.last,
                    got.out_byte, got.is_status, got.stop_cause, got.last));
            end
        endfunction
    endclass

endpackage

### sim/tb_top.sv
// top-level testbench of three_phase_pattern_section_extractor
// drives items, pattern loads and length registers, checks result transfers
// depends on tppse_pkg, tppse_sb_pkg and the block itself
module tb_top;
    import tppse_pkg::*;
    import tppse_sb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_NONE    = 2'd3;
    localparam logic [1:0] SEL_NONE    = 2'd3;
    localparam int         ITEM_TARGET = 470;
    localparam int         HOLD_CYCLES = 300;
    localparam int         STALL_LIMIT = 3000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    t_item                i_item = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    t_result              o_result;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    section_scoreboard sb;
    logic [7:0]        pat_img [NUM_PATTERNS][WINDOW_BYTES_DEF];
    int                pat_ready [NUM_PATTERNS] = '{0, 0, 0};
    bit                no_idle = 1'b0;
    int                rx_hold_req = 0;
    int                n_items = 0;
    int                n_sections = 0;
    int                n_settings = 0;

    three_phase_pattern_section_extractor dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_item    (i_item),
        .empty     (empty),
        .pop       (pop),
        .o_result  (o_result),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_item make_item(logic [1:0] cmd, logic [1:0] sel, logic [5:0] pos,
                                        logic [7:0] v);
        t_item it;
        it.cmd = cmd;
        it.pattern_select = sel;
        it.pattern_position = pos;
        it.value = v;
        it.chunk_end = 1'($urandom_range(1));
        return it;
    endfunction

    task automatic send(t_item it);
        if (!no_idle) begin
            while ($urandom_range(99) < 25) begin
                push <= 1'b0;
                @(posedge i_clk);
            end
        end
        push <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        if (sb.note_item(it)) n_items++;
        if (it.cmd == CMD_LOAD && it.pattern_select < NUM_PATTERNS)
            pat_img[it.pattern_select][it.pattern_position] = it.value;
    endtask

    task automatic scan_byte(logic [7:0] v);
        send(make_item(CMD_SCAN, 2'($urandom_range(3)), 6'($urandom_range(63)), v));
    endtask

    task automatic load_byte(logic [1:0] sel, logic [5:0] pos, logic [7:0] v);
        send(make_item(CMD_LOAD, sel, pos, v));
    endtask

    task automatic restart_scan();
        send(make_item(CMD_RESTART, 2'($urandom_range(3)), 6'($urandom_range(63)),
                       8'($urandom_range(255))));
    endtask

    task automatic noise_item();
        send(make_item(2'($urandom_range(3)), 2'($urandom_range(3)), 6'($urandom_range(63)),
                       8'($urandom_range(255))));
    endtask

    // text byte; clean ones never carry a newline or noise
    task automatic text_byte(bit clean);
        logic [7:0] v;
        v = 8'($urandom_range(255));
        if (!clean && $urandom_range(19) == 0) begin
            noise_item();
        end else begin
            if (clean && v == NEWLINE_BYTE) v = 8'h20;
            scan_byte(v);
        end
    endtask

    // wait until every expected transfer is out and the block is quiet
    task automatic settle();
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.set_length(idx, v);
    endtask

    task automatic configure(logic [CFG_W-1:0] t_len, logic [CFG_W-1:0] m_len,
                             logic [CFG_W-1:0] e_len);
        settle();
        cfg_write(CFG_TRIGGER_LEN, t_len);
        cfg_write(CFG_MATCH_LEN, m_len);
        cfg_write(CFG_END_LEN, e_len);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // every pattern byte inside the current lengths gets written before any scan
    task automatic load_patterns();
        int n;
        for (int p = 0; p < NUM_PATTERNS; p++) begin
            n = sb.span(sb.lengths[p]);
            for (int pos = 0; pos < n; pos++) begin
                if (pos < 8 || pos >= pat_ready[p])
                    load_byte(2'(p), 6'(pos), 8'($urandom_range(255)));
            end
            if (n > pat_ready[p]) pat_ready[p] = n;
        end
    endtask

    task automatic send_pattern(int p, bit broken);
        int n;
        n = sb.span(sb.lengths[p]);
        for (int i = 0; i < n; i++) begin
            if (!(broken && i == n / 2)) scan_byte(pat_img[p][i]);
        end
    endtask

    task automatic run_section(bit heavy);
        int nlines;
        int len;
        int r;
        if ($urandom_range(7) != 0) restart_scan();
        repeat ($urandom_range(2)) text_byte(1'b0);
        send_pattern(SEL_TRIGGER, $urandom_range(9) == 0);
        repeat ($urandom_range(2)) text_byte(1'b0);
        send_pattern(SEL_MATCH, $urandom_range(9) == 0);
        nlines = heavy ? 2 : $urandom_range(3);
        repeat (nlines) begin
            if (heavy) len = $urandom_range(48, 63);
            else if ($urandom_range(7) == 0) len = $urandom_range(16, 63);
            else len = $urandom_range(6);
            repeat (len) text_byte(heavy);
            scan_byte(NEWLINE_BYTE);
        end
        r = $urandom_range(11);
        if (r < 9) begin
            send_pattern(SEL_END, $urandom_range(11) == 0);
        end else if (r < 11) begin
            repeat (LINE_BYTES_DEF) text_byte(1'b1);
            if ($urandom_range(1) == 0) scan_byte(NEWLINE_BYTE);
            else text_byte(1'b1);
        end
        n_sections++;
    endtask

    function automatic logic [CFG_W-1:0] pick_len();
        int r;
        r = $urandom_range(15);
        if (r == 0) return '0;
        if (r == 1) return CFG_W'($urandom_range(64, 127));
        if (r <= 3) return CFG_W'($urandom_range(7, 20));
        return CFG_W'($urandom_range(1, 5));
    endfunction

    // result side
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) sb.check_result(o_result);
            if (rx_hold_req > 0) begin
                hold_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= no_idle || ($urandom_range(99) >= 25);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) quiet = 0;
            else quiet++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        int k;
        sb = new();
        foreach (pat_img[p, i]) pat_img[p][i] = 8'h00;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: ignored codes, single-byte patterns, zero bytes, empty line, finish
        send(make_item(CMD_NONE, SEL_TRIGGER, 6'd0, 8'hFF));
        load_byte(SEL_NONE, 6'd5, 8'h11);
        load_byte(SEL_TRIGGER, 6'd0, 8'hFF);
        load_byte(SEL_MATCH, 6'd0, 8'h00);
        load_byte(SEL_END, 6'd0, 8'h7E);
        pat_ready = '{1, 1, 1};
        scan_byte(8'hFF);
        scan_byte(8'h00);
        scan_byte(8'h00);
        scan_byte(8'h41);
        scan_byte(NEWLINE_BYTE);
        scan_byte(NEWLINE_BYTE);
        scan_byte(8'h80);
        scan_byte(8'h7E);
        scan_byte(8'h55);
        load_byte(SEL_TRIGGER, 6'd63, 8'hA5);
        restart_scan();
        scan_byte(8'hFF);
        scan_byte(8'h00);
        scan_byte(8'h7E);

        k = 0;
        while (n_items < ITEM_TARGET || n_sections < 5) begin
            if (k == 0) configure('0, '0, '0);
            else if (k == 4) configure('0, '1, '0);
            else if (k % 2 == 0 || k == 5) configure(pick_len(), pick_len(), pick_len());
            if (k == 0 || k == 4 || k == 5 || k % 2 == 0) load_patterns();
            if (k == 3) rx_hold_req = HOLD_CYCLES;
            no_idle = (k >= 4 && k < 6);
            run_section(k == 3);
            k++;
        end
        no_idle = 1'b0;
        settle();

        $display("tb_top: %0d items, %0d result transfers over %0d sections, %0d length settings",
                 n_items, sb.checked, n_sections, n_settings);
        $display("tb_top: %0d mismatches", sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/tppse_pkg.sv
hdl/tppse_front.sv
hdl/tppse_back.sv
hdl/tppse_out_q.sv
hdl/three_phase_pattern_section_extractor.sv
sim/tppse_sb_pkg.sv
sim/tb_top.sv
